FILE: rtl/core/u8d_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  // Front-to-back queue depth and derived widths
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int ByteW = 8;
  localparam int CpW   = 21;

  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [2:0]       Lead2Pfx   = 3'h6;   // 110xxxxx
  localparam logic [3:0]       Lead3Pfx   = 4'hE;   // 1110xxxx
  localparam logic [4:0]       Lead4Pfx   = 5'h1E;  // 11110xxx

  // Sequence length codes: continuation bytes a lead byte asks for
  localparam logic [1:0] SeqNone = 2'd0;
  localparam logic [1:0] SeqOne  = 2'd1;
  localparam logic [1:0] SeqTwo  = 2'd2;
  localparam logic [1:0] SeqThr  = 2'd3;

  // One queue entry: one or two results
  typedef struct packed {
    logic [CpW-1:0] cp0;
    logic           pv0;
    logic           end0;
    logic           has2;   // second result follows: valid, end-marked
    logic [CpW-1:0] cp1;
  } u8d_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } u8d_qstat_t;

  function automatic logic [1:0] seq_len(input logic [ByteW-1:0] c);
    logic [1:0] n;
    n = SeqNone;
    if (c[7:5] == Lead2Pfx) n = SeqOne;
    else if (c[7:4] == Lead3Pfx) n = SeqTwo;
    else if (c[7:3] == Lead4Pfx) n = SeqThr;
    return n;
  endfunction

  function automatic logic [CpW-1:0] combine(input logic [ByteW-1:0] lead,
                                             input logic [ByteW-1:0] t0,
                                             input logic [ByteW-1:0] t1,
                                             input logic [ByteW-1:0] t2,
                                             input logic [1:0]       n);
    logic [CpW-1:0] cp;
    unique case (n)
      SeqOne:  cp = {10'd0, lead[4:0], t0[5:0]};
      SeqTwo:  cp = {5'd0, lead[3:0], t0[5:0], t1[5:0]};
      SeqThr:  cp = {lead[2:0], t0[5:0], t1[5:0], t2[5:0]};
      default: cp = '0;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/u8d_ifs.sv
// Stream interfaces for the byte input and code point output channels.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        point_valid;
  logic        end_mark;

  modport source (output valid, output code_point, output point_valid,
                  output end_mark, input ready);
  modport sink   (input valid, input code_point, input point_valid,
                  input end_mark, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8_to_codepoint_decoder_core.sv
// Top level of the UTF-8 to code point decoder.
// Throughput: one byte per cycle while the queue has room; an entry carrying two results
//   (string ends inside a sequence whose bytes re-decode to two code points) takes the output slot twice.
// After its byte is accepted, a result passes a queue write, then an output register
//   load, and is held back further while the output is stalled.
// Reset: synchronous active-low rst_n clears the open sequence, the 4-entry
//   queue pointers and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_codepoint_decoder_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);
  import u8d_pkg::*;

  // front/back coupling
  logic       push;
  u8d_entry_t push_ent;
  logic       pop;
  u8d_entry_t head;
  u8d_qstat_t stat;
  logic       in_acc;

  // Input side stalls only when the queue is full; the front writes at most
  // one entry per accepted transaction.
  assign in_ch.ready = !stat.full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  u8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .byte_in    (in_ch.byte_in),
    .string_end (in_ch.string_end),
    .push       (push),
    .push_ent   (push_ent)
  );

  u8d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // Back end drains the queue into a registered output slot; the slot reloads
  // in the same cycle it is taken, so the output sustains one per cycle while the queue holds entries.
  u8d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/core/u8d_front.sv
// Front end: byte classification, sequence collection, entry build.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          byte_in,
  input  wire logic                string_end,
  output logic                     push,
  output u8d_pkg::u8d_entry_t      push_ent
);
  import u8d_pkg::*;

  logic [ByteW-1:0] lead_r, lead_nxt;
  logic [15:0]      tail_r, tail_nxt;
  logic [1:0]       need_r, need_nxt;
  logic [1:0]       held_r, held_nxt;

  logic [ByteW-1:0] t0, t1;
  logic [1:0]       held_inc;
  logic             complete;
  logic [1:0]       len_in, len_x0;
  logic             in_ascii, x0_ascii;

  assign t0       = (held_r == 2'd0) ? byte_in : tail_r[7:0];
  assign t1       = (held_r == 2'd1) ? byte_in : tail_r[15:8];
  assign held_inc = held_r + 2'd1;
  assign complete = (held_inc >= need_r);
  assign len_in   = seq_len(byte_in);
  assign len_x0   = seq_len(t0);
  assign in_ascii = (byte_in < AsciiLimit);
  assign x0_ascii = (t0 < AsciiLimit);

  always_comb begin
    lead_nxt = lead_r;
    tail_nxt = tail_r;
    need_nxt = need_r;
    held_nxt = held_r;
    push     = 1'b0;
    push_ent = '0;
    if (acc) begin
      if (need_r == SeqNone) begin
        if (in_ascii) begin
          push          = 1'b1;
          push_ent.cp0  = {13'd0, byte_in};
          push_ent.pv0  = 1'b1;
          push_ent.end0 = string_end;
        end else if (string_end) begin
          push          = 1'b1;
          push_ent.end0 = 1'b1;
        end else if (len_in != SeqNone) begin
          lead_nxt = byte_in;
          tail_nxt = '0;
          need_nxt = len_in;
          held_nxt = 2'd0;
        end
      end else if (complete) begin
        push          = 1'b1;
        push_ent.cp0  = combine(lead_r, t0, t1, byte_in, need_r);
        push_ent.pv0  = 1'b1;
        push_ent.end0 = string_end;
        need_nxt      = SeqNone;
        held_nxt      = 2'd0;
      end else if (!string_end) begin
        if (held_r == 2'd0) tail_nxt[7:0] = byte_in;
        else tail_nxt[15:8] = byte_in;
        held_nxt = held_inc;
      end else begin
        // truncated: drop the lead, re-decode the collected bytes
        push          = 1'b1;
        push_ent.end0 = 1'b1;
        need_nxt      = SeqNone;
        held_nxt      = 2'd0;
        if (held_inc == 2'd1) begin
          if (in_ascii) begin
            push_ent.cp0 = {13'd0, byte_in};
            push_ent.pv0 = 1'b1;
          end
        end else if (x0_ascii) begin
          push_ent.cp0 = {13'd0, t0};
          push_ent.pv0 = 1'b1;
          if (in_ascii) begin
            push_ent.end0 = 1'b0;
            push_ent.has2 = 1'b1;
            push_ent.cp1  = {13'd0, byte_in};
          end
        end else if (len_x0 == SeqOne) begin
          push_ent.cp0 = combine(t0, byte_in, byte_in, byte_in, SeqOne);
          push_ent.pv0 = 1'b1;
        end else if (in_ascii) begin
          push_ent.cp0 = {13'd0, byte_in};
          push_ent.pv0 = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      tail_r <= '0;
      need_r <= SeqNone;
      held_r <= 2'd0;
    end else begin
      lead_r <= lead_nxt;
      tail_r <= tail_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8d_queue.sv
// Small FIFO of decoded entries between front and back.
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire u8d_pkg::u8d_entry_t push_ent,
  input  wire logic                pop,
  output u8d_pkg::u8d_entry_t      head,
  output u8d_pkg::u8d_qstat_t      stat
);
  import u8d_pkg::*;

  u8d_entry_t       q_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat       = '{empty: (cnt_r == '0), full: (cnt_r == QCntW'(QDepth))};
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(do_push);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(do_pop);
    cnt_nxt    = cnt_r + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8d_back.sv
// Back end: unpacks queue entries into the registered output channel.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u8d_pkg::u8d_entry_t head,
  input  wire u8d_pkg::u8d_qstat_t stat,
  output logic                     pop,
  u8d_out_if.source                out_ch
);
  import u8d_pkg::*;

  logic           out_valid_r, out_valid_nxt;
  logic           phase_r, phase_nxt;
  logic [CpW-1:0] cp_r, cp_nxt;
  logic           pv_r, pv_nxt;
  logic           end_r, end_nxt;
  logic           load_en;

  assign load_en = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    cp_nxt        = cp_r;
    pv_nxt        = pv_r;
    end_nxt       = end_r;
    pop           = 1'b0;
    if (load_en) begin
      out_valid_nxt = !stat.empty;
      if (!stat.empty) begin
        if (phase_r) begin
          // second half of a two-result entry
          cp_nxt    = head.cp1;
          pv_nxt    = 1'b1;
          end_nxt   = 1'b1;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end else begin
          cp_nxt    = head.cp0;
          pv_nxt    = head.pv0;
          end_nxt   = head.end0;
          phase_nxt = head.has2;
          pop       = !head.has2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    pv_r  <= pv_nxt;
    end_r <= end_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = cp_r;
  assign out_ch.point_valid = pv_r;
  assign out_ch.end_mark    = end_r;

endmodule

`default_nettype wire

FILE: tb/utf8_to_codepoint_decoder_core_tb.sv
// Self-checking testbench for the UTF-8 to code point decoder core.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_codepoint_decoder_core_tb;
  import u8d_pkg::*;

  // Hard stop for a hung run.
  localparam int CycleLimit = 200000;
  // Idle odds, in percent, on each side.
  localparam int IdlePct = 9;
  // Receiver hold-off: starts once this many bytes went in, lasts this many cycles.
  localparam int HoldAfter = 500;
  localparam int HoldCycles = 300;
  // Window, in accepted bytes, where neither side idles.
  localparam int QuietLo = 900;
  localparam int QuietHi = 1200;
  localparam int RandomBytes = 1550;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             last;
  } byte_item_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           pv;
    logic           em;
  } code_result_t;

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_to_codepoint_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bytes waiting to go out, and code points the decoder still owes us.
  byte_item_t   byte_q [$];
  code_result_t cp_expect [$];

  int n_queued = 0;        // bytes handed to the driver (initial block only)
  int bytes_accepted = 0;  // input transactions seen (monitor only)
  int results_seen = 0;
  int errors = 0;
  int cycle_cnt = 0;
  logic byte_taken = 1'b0; // input transaction at the last rising edge

  // Shadow of the decoder's open sequence.
  logic [ByteW-1:0] seq_lead;
  logic [23:0]      seq_tail;   // collected byte k at bits 8k+7..8k
  logic [1:0]       seq_need;
  logic [1:0]       seq_held;

  function automatic bit quiet_span();
    return bytes_accepted >= QuietLo && bytes_accepted < QuietHi;
  endfunction

  // Continuation bytes a lead byte asks for; SeqNone for anything else.
  function automatic logic [1:0] lead_span(input logic [ByteW-1:0] b);
    if (b[7:5] == Lead2Pfx) return SeqOne;
    if (b[7:4] == Lead3Pfx) return SeqTwo;
    if (b[7:3] == Lead4Pfx) return SeqThr;
    return SeqNone;
  endfunction

  // Lead payload bits, then six bits from each tail byte, oldest first.
  function automatic logic [CpW-1:0] assemble_point(input logic [ByteW-1:0] lead,
                                                    input logic [23:0] tail,
                                                    input logic [1:0] n);
    logic [CpW-1:0] acc;
    int k;
    case (n)
      SeqOne:  acc = CpW'(lead[4:0]);
      SeqTwo:  acc = CpW'(lead[3:0]);
      default: acc = CpW'(lead[2:0]);
    endcase
    for (k = 0; k < int'(n); k++) acc = {acc[CpW-7:0], tail[8*k +: 6]};
    return acc;
  endfunction

  task automatic owe_point(input logic [CpW-1:0] cp, input logic pv, input logic em);
    code_result_t r;
    r.cp = cp;
    r.pv = pv;
    r.em = em;
    cp_expect = {cp_expect, r};
  endtask

  task automatic forget_sequence();
    seq_lead = '0;
    seq_tail = '0;
    seq_need = SeqNone;
    seq_held = 2'd0;
  endtask

  // Advance the shadow decoder by one byte and queue what it must emit.
  task automatic predict_byte(input logic [ByteW-1:0] b, input logic last);
    logic [2:0]       got;
    logic [23:0]      held_bytes;
    logic [ByteW-1:0] c;
    logic [1:0]       span;
    logic [CpW-1:0]   pts [0:2];
    int i;
    int npts;
    int k;
    if (seq_need == SeqNone) begin
      if (b < AsciiLimit) begin
        owe_point(CpW'(b), 1'b1, last);
      end else if (last) begin
        owe_point('0, 1'b0, 1'b1);  // stray or lone lead at end: bare end mark
      end else if (lead_span(b) != SeqNone) begin
        seq_lead = b;
        seq_tail = '0;
        seq_need = lead_span(b);
        seq_held = 2'd0;
      end
    end else begin
      seq_tail[8*seq_held +: 8] = b;
      got = {1'b0, seq_held} + 3'd1;
      if (got >= {1'b0, seq_need}) begin
        owe_point(assemble_point(seq_lead, seq_tail, seq_need), 1'b1, last);
        forget_sequence();
      end else if (!last) begin
        seq_held = got[1:0];
      end else begin
        // String cut short: lead is lost, the tail bytes are decoded afresh
        // knowing nothing comes after them.
        held_bytes = seq_tail;
        forget_sequence();
        i = 0;
        npts = 0;
        while (i < int'(got)) begin
          c = held_bytes[8*i +: 8];
          span = lead_span(c);
          if (c < AsciiLimit) begin
            pts[npts] = CpW'(c);
            npts++;
            i++;
          end else if (span != SeqNone && i + int'(span) < int'(got)) begin
            pts[npts] = assemble_point(c, held_bytes >> (8 * (i + 1)), span);
            npts++;
            i += 1 + int'(span);
          end else begin
            i++;
          end
        end
        if (npts == 0) begin
          owe_point('0, 1'b0, 1'b1);
        end else begin
          if (npts > 2) npts = 2;
          for (k = 0; k < npts; k++) owe_point(pts[k], 1'b1, k == npts - 1);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("ERROR result %0d: %s = 0x%0h, expected 0x%0h", results_seen, what, got, want);
  endtask

  // Monitor: counts cycles, tracks input transactions into the predictor and
  // checks every output transaction against the oldest owed result.
  always @(posedge clk) begin : watch_ports
    code_result_t want;
    if (rst_n) begin
      cycle_cnt <= cycle_cnt + 1;
      byte_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.byte_in, in_ch.string_end);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (cp_expect.size() == 0) begin
          report_mismatch("unexpected result, code_point", int'(out_ch.code_point), 0);
        end else begin
          want = cp_expect.pop_front();
          if (out_ch.code_point !== want.cp)
            report_mismatch("code_point", int'(out_ch.code_point), int'(want.cp));
          if (out_ch.point_valid !== want.pv)
            report_mismatch("point_valid", int'(out_ch.point_valid), int'(want.pv));
          if (out_ch.end_mark !== want.em)
            report_mismatch("end_mark", int'(out_ch.end_mark), int'(want.em));
        end
        results_seen <= results_seen + 1;
      end
      if (cycle_cnt >= CycleLimit) begin
        $display("utf8_to_codepoint_decoder_core regression: fail");
        $finish;
      end
    end
  end

  // Driver: presents the next queued byte at the falling edge, holds it until
  // taken, and idles now and then between transactions.
  always @(negedge clk) begin : drive_bytes
    byte_item_t nxt;
    if (rst_n && (!in_ch.valid || byte_taken)) begin
      if (byte_q.size() != 0 && (quiet_span() || $urandom_range(0, 99) >= IdlePct)) begin
        nxt = byte_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.byte_in <= nxt.b;
        in_ch.string_end <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the internal queue
  // fills and the input side has to back-pressure.
  int  hold_left = 0;
  bit  hold_used = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_used && bytes_accepted >= HoldAfter) begin
        hold_used <= 1'b1;
        hold_left <= HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_span() || $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  task automatic add_byte(input logic [ByteW-1:0] b, input logic last);
    byte_item_t it;
    it.b = b;
    it.last = last;
    byte_q = {byte_q, it};
    n_queued++;
  endtask

  // Any byte, weighted toward the classes that matter to the decoder.
  function automatic logic [ByteW-1:0] any_byte();
    case ($urandom_range(0, 3))
      0:       return ByteW'($urandom_range(0, 8'h7F));
      1:       return ByteW'($urandom_range(8'hC0, 8'hF7));
      2:       return ByteW'($urandom_range(8'h80, 8'hBF));
      default: return ByteW'($urandom_range(0, 8'hFF));
    endcase
  endfunction

  // Tail bytes go unchecked, so now and then slip in something else.
  function automatic logic [ByteW-1:0] tail_byte();
    if ($urandom_range(0, 9) == 0) return any_byte();
    return ByteW'($urandom_range(8'h80, 8'hBF));
  endfunction

  // One string: mostly well-formed code points; sometimes a stray byte, and
  // sometimes the string stops inside its last sequence.
  task automatic add_random_string();
    int npts;
    int k;
    int len;
    int cut;
    int j;
    bit tail_end;
    logic [ByteW-1:0] lead;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 5);
      for (j = 0; j < len; j++) add_byte(any_byte(), j == len - 1);
    end else begin
      npts = $urandom_range(1, 6);
      for (k = 0; k < npts; k++) begin
        tail_end = (k == npts - 1);
        if ($urandom_range(0, 99) < 8) begin
          if ($urandom_range(0, 1) == 0) add_byte(ByteW'($urandom_range(8'h80, 8'hBF)), tail_end);
          else add_byte(ByteW'($urandom_range(8'hF8, 8'hFF)), tail_end);
        end else begin
          len = $urandom_range(1, 4);
          case (len)
            1:       lead = ByteW'($urandom_range(0, 8'h7F));
            2:       lead = 8'hC0 | ByteW'($urandom_range(0, 31));
            3:       lead = 8'hE0 | ByteW'($urandom_range(0, 15));
            default: lead = 8'hF0 | ByteW'($urandom_range(0, 7));
          endcase
          if (len > 1 && tail_end && $urandom_range(0, 99) < 30) begin
            // cut short: ASCII and leads in the tail make the re-decode interesting
            cut = $urandom_range(0, len - 2);
            add_byte(lead, cut == 0);
            for (j = 0; j < cut; j++) add_byte(any_byte(), j == cut - 1);
          end else begin
            add_byte(lead, tail_end && len == 1);
            for (j = 1; j < len; j++) add_byte(tail_byte(), tail_end && j == len - 1);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.string_end = 1'b0;
    out_ch.ready = 1'b0;
    forget_sequence();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ASCII extremes, each sequence length up to the largest code
    // point, stray byte at end, lead at end, strings cut short inside a
    // sequence, and a tail byte that is not a continuation byte.
    add_byte(8'h00, 1'b0); add_byte(8'h7F, 1'b1);
    add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
    add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h80, 1'b0); add_byte(8'hC3, 1'b1);
    add_byte(8'hF0, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b1);
    add_byte(8'hE0, 1'b0); add_byte(8'hC3, 1'b1);
    add_byte(8'hF0, 1'b0); add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b1);
    add_byte(8'hC0, 1'b0); add_byte(8'h00, 1'b1);

    // Sender pauses here until the directed part has fully drained.
    while (bytes_accepted != n_queued || cp_expect.size() != 0) @(negedge clk);

    while (n_queued < RandomBytes + 24) add_random_string();

    while (bytes_accepted != n_queued || cp_expect.size() != 0) @(negedge clk);
    // Room for any late, spurious result to show up.
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("utf8_to_codepoint_decoder_core regression: pass");
    end else begin
      $display("utf8_to_codepoint_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_ifs.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_to_codepoint_decoder_core.sv
tb/utf8_to_codepoint_decoder_core_tb.sv
